// ===== sv/bse_pkg.sv =====
// shared widths, request codes and control types for the bitmap set engine
package bse_pkg;

  localparam int DEF_WORD_BITS = 64;
  localparam int DEF_NUM_WORDS = 8;
  localparam int DEF_CNT_W     = $clog2(DEF_WORD_BITS * DEF_NUM_WORDS + 1);

  localparam int REQ_W  = 4;
  localparam int ITEM_W = 9;
  localparam int WIDX_W = 3;
  localparam int DATA_W = 64;
  localparam int LEN_W  = 9;

  localparam logic [REQ_W-1:0] REQ_ADD     = 4'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_TEST    = 4'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_FILL    = 4'd4;
  localparam logic [REQ_W-1:0] REQ_COMPL   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_AND     = 4'd6;
  localparam logic [REQ_W-1:0] REQ_OR      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_ANDNOT  = 4'd8;
  localparam logic [REQ_W-1:0] REQ_WRITE   = 4'd9;
  localparam logic [REQ_W-1:0] REQ_READ    = 4'd10;
  localparam logic [REQ_W-1:0] REQ_EMPTY   = 4'd11;
  localparam logic [REQ_W-1:0] REQ_START   = 4'd12;
  localparam logic [REQ_W-1:0] REQ_NEXT    = 4'd13;

  typedef enum logic [3:0] {
    ALU_PASS  = 4'd0,
    ALU_SET   = 4'd1,
    ALU_CLR   = 4'd2,
    ALU_AND   = 4'd3,
    ALU_OR    = 4'd4,
    ALU_ANDN  = 4'd5,
    ALU_LOAD  = 4'd6,
    ALU_FILL  = 4'd7,
    ALU_COMPL = 4'd8
  } alu_op_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } mem_ctl_t;

endpackage

// ===== sv/bse_req_if.sv =====
// request channel carrying one set operation per transaction
interface bse_req_if import bse_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ITEM_W-1:0] item_index;
  logic [WIDX_W-1:0] word_index;
  logic [DATA_W-1:0] word_data;

  modport source (output valid, req_type, item_index, word_index, word_data, input ready);
  modport sink   (input valid, req_type, item_index, word_index, word_data, output ready);
endinterface

// ===== sv/bse_rsp_if.sv =====
// response channel carrying one result per transaction
interface bse_rsp_if import bse_pkg::*;;
  logic              valid;
  logic              ready;
  logic              flag;
  logic [ITEM_W-1:0] member_index;
  logic [DATA_W-1:0] word_out;

  modport source (output valid, flag, member_index, word_out, input ready);
  modport sink   (input valid, flag, member_index, word_out, output ready);
endinterface

// ===== sv/bse_mem.sv =====
// word store with per-word valid bits, one read and one write port
module bse_mem import bse_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int NUM_WORDS = DEF_NUM_WORDS,
  parameter int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mem_ctl_t             ctl,
  input  logic [ADDR_W-1:0]    rd_addr,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] words_r [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      words_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= words_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // words not written since reset or the last clear read as zero
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== sv/bse_alu.sv =====
// shared word unit: bit and word logic, length mask, search for the highest-numbered member in a word
module bse_alu import bse_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int CNT_W     = DEF_CNT_W
) (
  input  alu_op_t                         op,
  input  logic [WORD_BITS-1:0]            opa,
  input  logic [WORD_BITS-1:0]            opb,
  input  logic [CNT_W-1:0]                len,
  input  logic [CNT_W-1:0]                base,
  output logic [WORD_BITS-1:0]            res,
  output logic                            masked_nz,
  output logic [$clog2(WORD_BITS)-1:0]    low_off,
  output logic [WORD_BITS-1:0]            low_clr
);

  localparam int POS_W = $clog2(WORD_BITS);

  logic [CNT_W-1:0]     span;
  logic [WORD_BITS-1:0] lmask;
  logic [WORD_BITS-1:0] low;

  // items below the set length within this word, first item at the msb
  always_comb begin
    span = len - base;
    if (len <= base) begin
      lmask = '0;
    end else if (int'(span) >= WORD_BITS) begin
      lmask = '1;
    end else begin
      lmask = ~({WORD_BITS{1'b1}} >> span);
    end
  end

  always_comb begin
    unique case (op)
      ALU_PASS:  res = opa;
      ALU_SET:   res = opa | opb;
      ALU_CLR:   res = opa & ~opb;
      ALU_AND:   res = opa & opb;
      ALU_OR:    res = opa | opb;
      ALU_ANDN:  res = opa & ~opb;
      ALU_LOAD:  res = opb;
      ALU_FILL:  res = lmask;
      ALU_COMPL: res = ~opa & lmask;
      default:   res = opa;
    endcase
  end

  assign masked_nz = |(opa & lmask);
  assign low       = opa & (~opa + WORD_BITS'(1));
  assign low_clr   = opa & ~low;

  // offset of the lowest set bit counted from the msb
  always_comb begin
    low_off = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        low_off = low_off | POS_W'(WORD_BITS - 1 - i);
      end
    end
  end

endmodule

// ===== sv/bitmap_set_engine.sv =====
// bitmap set engine: item set as stored words, driven by a small sequencer
// word and item requests read one word and then act on it; fill, complement and empty do so for every word in turn;
// clear empties the set on accept, start loads the first word, next loads words until a member or the last word
// one request in flight; the next is accepted the cycle after its result is posted
// synchronous reset empties the set, zeroes the iterator and the length register
module bitmap_set_engine import bse_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int NUM_WORDS = DEF_NUM_WORDS
) (
  input  logic             clk,
  input  logic             rst_n,
  bse_req_if.sink          in_req,
  bse_rsp_if.source        out_rsp,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  localparam int AW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CAPACITY = NUM_WORDS * WORD_BITS;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int POS_W    = $clog2(WORD_BITS);
  localparam int DIV_SH   = ITEM_W + POS_W;
  localparam int DIV_MUL  = (2 ** DIV_SH + WORD_BITS - 1) / WORD_BITS;
  localparam logic [WORD_BITS-1:0] TOP_BIT = {1'b1, {(WORD_BITS - 1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ADDR = 9'b000000010,
    S_WORD = 9'b000000100,
    S_EXEC = 9'b000001000,
    S_WRD  = 9'b000010000,
    S_WMOD = 9'b000100000,
    S_NEXT = 9'b001000000,
    S_NLD  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [ITEM_W-1:0]    item_r, item_nxt;
  logic [WIDX_W-1:0]    widx_r, widx_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;
  logic [ITEM_W-1:0]    q_r, q_nxt;
  logic [WORD_BITS-1:0] bitmask_r, bitmask_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [CW-1:0]        base_r, base_nxt;
  logic                 flag_r, flag_nxt;
  logic [ITEM_W-1:0]    member_r, member_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [AW-1:0]        iter_word_r, iter_word_nxt;
  logic [CW-1:0]        iter_base_r, iter_base_nxt;
  logic [WORD_BITS-1:0] iter_rem_r, iter_rem_nxt;
  logic [LEN_W-1:0]     set_len_r, set_len_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_flag_r, out_flag_nxt;
  logic [ITEM_W-1:0]    out_member_r, out_member_nxt;
  logic [DATA_W-1:0]    out_word_r, out_word_nxt;

  mem_ctl_t             mem_ctl;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  alu_op_t              alu_op;
  logic [WORD_BITS-1:0] alu_a, alu_b, alu_res, low_clr;
  logic                 masked_nz;
  logic [POS_W-1:0]     low_off;
  logic [CW-1:0]        eff_len;
  logic [31:0]          div_prod;
  logic [ITEM_W-1:0]    q_prod;
  logic [POS_W-1:0]     bit_pos;
  logic                 in_acc;

  assign eff_len  = (int'(set_len_r) > CAPACITY) ? CW'(CAPACITY) : CW'(set_len_r);
  assign div_prod = 32'(in_req.item_index) * 32'(DIV_MUL);
  assign q_prod   = ITEM_W'(int'(q_r) * WORD_BITS);
  assign bit_pos  = POS_W'(item_r - q_prod);
  assign in_acc   = in_req.valid && in_req.ready;

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.flag         = out_flag_r;
  assign out_rsp.member_index = out_member_r;
  assign out_rsp.word_out     = out_word_r;

  bse_mem #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS),
    .ADDR_W    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (addr_r),
    .wr_data (alu_res),
    .rd_data (rd_data)
  );

  bse_alu #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CW)
  ) u_alu (
    .op        (alu_op),
    .opa       (alu_a),
    .opb       (alu_b),
    .len       (eff_len),
    .base      (base_r),
    .res       (alu_res),
    .masked_nz (masked_nz),
    .low_off   (low_off),
    .low_clr   (low_clr)
  );

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    item_nxt       = item_r;
    widx_nxt       = widx_r;
    data_nxt       = data_r;
    q_nxt          = q_r;
    bitmask_nxt    = bitmask_r;
    addr_nxt       = addr_r;
    base_nxt       = base_r;
    flag_nxt       = flag_r;
    member_nxt     = member_r;
    word_nxt       = word_r;
    iter_word_nxt  = iter_word_r;
    iter_base_nxt  = iter_base_r;
    iter_rem_nxt   = iter_rem_r;
    set_len_nxt    = set_len_r;
    out_valid_nxt  = out_valid_r;
    out_flag_nxt   = out_flag_r;
    out_member_nxt = out_member_r;
    out_word_nxt   = out_word_r;
    mem_ctl        = '0;
    rd_addr        = addr_r;
    alu_op         = ALU_PASS;
    alu_a          = rd_data;
    alu_b          = data_r;

    if (cfg_wr_en) begin
      set_len_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_req.req_type;
          item_nxt   = in_req.item_index;
          widx_nxt   = in_req.word_index;
          data_nxt   = in_req.word_data[WORD_BITS-1:0];
          q_nxt      = ITEM_W'(div_prod >> DIV_SH);
          addr_nxt   = '0;
          base_nxt   = '0;
          flag_nxt   = 1'b0;
          member_nxt = '0;
          word_nxt   = '0;
          unique case (in_req.req_type)
            REQ_ADD, REQ_REMOVE, REQ_TEST: state_nxt = S_ADDR;
            REQ_CLEAR: begin
              mem_ctl.clear_all = 1'b1;
              state_nxt         = S_DONE;
            end
            REQ_FILL, REQ_COMPL: state_nxt = S_WRD;
            REQ_EMPTY: begin
              flag_nxt  = 1'b1;
              state_nxt = S_WRD;
            end
            REQ_AND, REQ_OR, REQ_ANDNOT, REQ_WRITE, REQ_READ: begin
              if (int'(in_req.word_index) < NUM_WORDS) begin
                addr_nxt  = AW'(in_req.word_index);
                state_nxt = S_WORD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            REQ_START: state_nxt = S_WORD;
            REQ_NEXT:  state_nxt = S_NEXT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ADDR: begin
        if (int'(item_r) < CAPACITY) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = AW'(q_r);
          addr_nxt      = AW'(q_r);
          bitmask_nxt   = TOP_BIT >> bit_pos;
          state_nxt     = S_EXEC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WORD: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        unique case (req_r)
          REQ_ADD: begin
            alu_op         = ALU_SET;
            alu_b          = bitmask_r;
            mem_ctl.wr_en  = 1'b1;
          end
          REQ_REMOVE: begin
            alu_op         = ALU_CLR;
            alu_b          = bitmask_r;
            mem_ctl.wr_en  = 1'b1;
          end
          REQ_TEST: begin
            flag_nxt = |(rd_data & bitmask_r);
          end
          REQ_AND: begin
            alu_op        = ALU_AND;
            mem_ctl.wr_en = 1'b1;
          end
          REQ_OR: begin
            alu_op        = ALU_OR;
            mem_ctl.wr_en = 1'b1;
          end
          REQ_ANDNOT: begin
            alu_op        = ALU_ANDN;
            mem_ctl.wr_en = 1'b1;
          end
          REQ_WRITE: begin
            alu_op        = ALU_LOAD;
            mem_ctl.wr_en = 1'b1;
          end
          REQ_START: begin
            iter_word_nxt = '0;
            iter_base_nxt = '0;
            iter_rem_nxt  = rd_data;
          end
          default: alu_op = ALU_PASS;
        endcase
        word_nxt  = alu_res;
        state_nxt = S_DONE;
      end
      S_WRD: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = S_WMOD;
      end
      S_WMOD: begin
        alu_op = (req_r == REQ_FILL) ? ALU_FILL : ALU_COMPL;
        if (req_r == REQ_EMPTY) begin
          if (masked_nz) begin
            flag_nxt = 1'b0;
          end
        end else begin
          mem_ctl.wr_en = 1'b1;
          if (int'(widx_r) == int'(addr_r)) begin
            word_nxt = alu_res;
          end
        end
        if (int'(addr_r) == NUM_WORDS - 1) begin
          state_nxt = S_DONE;
        end else begin
          addr_nxt  = addr_r + AW'(1);
          base_nxt  = base_r + CW'(WORD_BITS);
          state_nxt = S_WRD;
        end
      end
      S_NEXT: begin
        alu_a = iter_rem_r;
        if (|iter_rem_r) begin
          iter_rem_nxt = low_clr;
          flag_nxt     = 1'b1;
          member_nxt   = ITEM_W'(iter_base_r + CW'(low_off));
          word_nxt     = low_clr;
          state_nxt    = S_DONE;
        end else if (int'(iter_word_r) == NUM_WORDS - 1) begin
          word_nxt  = iter_rem_r;
          state_nxt = S_DONE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = iter_word_r + AW'(1);
          iter_word_nxt = iter_word_r + AW'(1);
          iter_base_nxt = iter_base_r + CW'(WORD_BITS);
          state_nxt     = S_NLD;
        end
      end
      S_NLD: begin
        iter_rem_nxt = rd_data;
        state_nxt    = S_NEXT;
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_flag_nxt   = flag_r;
          out_member_nxt = member_r;
          out_word_nxt   = DATA_W'(word_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      set_len_r   <= '0;
      iter_word_r <= '0;
      iter_base_r <= '0;
      iter_rem_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      set_len_r   <= set_len_nxt;
      iter_word_r <= iter_word_nxt;
      iter_base_r <= iter_base_nxt;
      iter_rem_r  <= iter_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    item_r       <= item_nxt;
    widx_r       <= widx_nxt;
    data_r       <= data_nxt;
    q_r          <= q_nxt;
    bitmask_r    <= bitmask_nxt;
    addr_r       <= addr_nxt;
    base_r       <= base_nxt;
    flag_r       <= flag_nxt;
    member_r     <= member_nxt;
    word_r       <= word_nxt;
    out_flag_r   <= out_flag_nxt;
    out_member_r <= out_member_nxt;
    out_word_r   <= out_word_nxt;
  end

endmodule

// ===== sv/bse_checker.sv =====
// port-level checks for the bitmap set engine, bound to the top level
module bse_checker import bse_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_flag,
  input logic [ITEM_W-1:0] out_member,
  input logic [DATA_W-1:0] out_word
);

  logic [1:0] pending_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted whose result has not been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flag) && $stable(out_member)
      && $stable(out_word))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready right after an accepted transaction");

  a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pending_r <= 2'd1)
    else $error("more than two transactions outstanding");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without an accepted transaction");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_flag   (out_rsp.flag),
  .out_member (out_rsp.member_index),
  .out_word   (out_rsp.word_out)
);
